### design/fra_pkg.sv
// shared types and constants of the fisheye remap address block
`default_nettype none
package fra_pkg;

   localparam int COORD_W = 12;
   localparam int CFG_W   = 13;
   localparam int FOCAL_W = 24;
   localparam int DIFF_W  = 14;
   localparam int SQ_W    = 26;
   localparam int R2_W    = 27;
   localparam int RAD_W   = 52;
   localparam int ROOT_W  = 26;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   // register indexes on the configuration port
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_CENTER_X     = 3'd2;
   localparam logic [2:0] REG_CENTER_Y     = 3'd3;
   localparam logic [2:0] REG_FOCAL_Q8     = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] src_col;
      logic [COORD_W-1:0] src_row;
      logic               inside_res;
   } rsp_type;

   // per-item data that rides along the root and divide pipelines
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic                     at_center;
   } side_type;

endpackage
`default_nettype wire

### design/fra_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module fra_sqrt
   import fra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [RAD_W-1:0]  in_rad,
   input  wire side_type          in_side,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      out_root,
   output side_type               out_side
);

   logic                valid_ff [ROOT_W];
   logic [RAD_W-1:0]    rad_ff   [ROOT_W];
   logic [ROOT_W+1:0]   rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [ROOT_W];
   side_type            side_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic              prev_valid;
      logic [RAD_W-1:0]  prev_rad;
      logic [ROOT_W+1:0] prev_rem;
      logic [ROOT_W-1:0] prev_root;
      side_type          prev_side;
      logic [ROOT_W+1:0] cur;
      logic [ROOT_W+1:0] trial;
      logic              take;
      logic [ROOT_W+1:0] rem_in;
      logic [ROOT_W-1:0] root_in;

      if (i == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rad   = in_rad;
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[i-1];
         assign prev_rad   = rad_ff[i-1];
         assign prev_rem   = rem_ff[i-1];
         assign prev_root  = root_ff[i-1];
         assign prev_side  = side_ff[i-1];
      end

      // bring down two radicand bits and try the next root bit
      always_comb begin
         cur     = {prev_rem[ROOT_W-1:0], prev_rad[RAD_W-1 -: 2]};
         trial   = {prev_root, 2'b01};
         take    = (cur >= trial);
         rem_in  = take ? (cur - trial) : cur;
         root_in = {prev_root[ROOT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i]  <= {prev_rad[RAD_W-3:0], 2'b00};
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule
`default_nettype wire

### design/fra_div.sv
// pipelined restoring divide giving the radial scale, one quotient bit per stage
`default_nettype none
module fra_div
   import fra_pkg::*;
#(
   parameter int FRAC_W = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [ROOT_W-1:0]  in_root,
   input  wire side_type           in_side,
   input  wire logic [FOCAL_W-1:0] focal,
   output logic                    out_valid,
   output logic [FRAC_W:0]         out_scale,
   output side_type                out_side
);

   localparam int NSTAGE = FRAC_W + 1;
   localparam int CW     = ROOT_W + FRAC_W;

   logic              valid_ff [NSTAGE];
   logic [ROOT_W-1:0] root_ff  [NSTAGE];
   logic [CW-1:0]     rem_ff   [NSTAGE];
   logic [FRAC_W:0]   quot_ff  [NSTAGE];
   side_type          side_ff  [NSTAGE];

   for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
      logic              prev_valid;
      logic [ROOT_W-1:0] prev_root;
      logic [CW-1:0]     prev_rem;
      logic [FRAC_W:0]   prev_quot;
      side_type          prev_side;
      logic [CW-1:0]     divisor;
      logic              take;
      logic [CW-1:0]     rem_in;

      if (i == 0) begin : g_first
         // numerator is 2 * focal scaled by the fraction width
         assign prev_valid = in_valid;
         assign prev_root  = in_root;
         assign prev_rem   = CW'({focal, 1'b0}) << FRAC_W;
         assign prev_quot  = '0;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[i-1];
         assign prev_root  = root_ff[i-1];
         assign prev_rem   = rem_ff[i-1];
         assign prev_quot  = quot_ff[i-1];
         assign prev_side  = side_ff[i-1];
      end

      // compare against the shifted root and subtract on success
      always_comb begin
         divisor = CW'(prev_root) << (FRAC_W - i);
         take    = (prev_rem >= divisor);
         rem_in  = take ? (prev_rem - divisor) : prev_rem;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[i] <= prev_root;
            rem_ff[i]  <= rem_in;
            quot_ff[i] <= {prev_quot[FRAC_W-1:0], take};
            side_ff[i] <= prev_side;
         end
      end
   end

   // unit scale at the center, otherwise the quotient never exceeds one
   assign out_valid = valid_ff[NSTAGE-1];
   assign out_side  = side_ff[NSTAGE-1];
   assign out_scale = side_ff[NSTAGE-1].at_center ? ((FRAC_W+1)'(1) << FRAC_W)
                                                   : quot_ff[NSTAGE-1];

endmodule
`default_nettype wire

### design/fra_map.sv
// one axis: scaled offset multiply, then position and bounds test
`default_nettype none
module fra_map
   import fra_pkg::*;
#(
   parameter int FRAC_W  = 16,
   parameter int MAX_DIM = 4096
)
(
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic signed [CFG_W-1:0]  center,
   input  wire logic        [CFG_W-1:0]  size,
   input  wire logic signed [DIFF_W-1:0] diff,
   input  wire logic        [FRAC_W:0]   scale,
   output logic                          in_bounds,
   output logic             [COORD_W-1:0] coord
);

   localparam int MW = DIFF_W + FRAC_W + 2;
   localparam int PW = MW + 1;
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int BW = (DW > CFG_W) ? DW : CFG_W;

   logic signed [MW-1:0] prod_ff;
   logic signed [MW-1:0] prod_in;
   logic signed [PW-1:0] pos;
   logic        [BW-1:0] limit;
   logic signed [PW-1:0] bound;

   // offset times scale
   assign prod_in = diff * $signed({1'b0, scale});

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // add the center and test against the image size
   always_comb begin
      pos       = PW'($signed({center, {FRAC_W{1'b0}}})) + PW'(prod_ff);
      limit     = (BW'(size) < BW'(MAX_DIM)) ? BW'(size) : BW'(MAX_DIM);
      bound     = $signed(PW'({limit, {FRAC_W{1'b0}}}));
      in_bounds = !pos[PW-1] && (pos < bound);
      coord     = in_bounds ? pos[FRAC_W +: COORD_W] : '0;
   end

endmodule
`default_nettype wire

### design/fisheye_remap_address_top.sv
// top level of the fisheye remap address generator
// Maps each output pixel (out_col, out_row) to the source pixel to fetch for
// equisolid fisheye correction, with an inside flag. One coordinate is taken
// every clock while the pipeline is not held. The pipeline has three front stages
// (offsets, squares, radicand), 26 square-root stages, SCALE_FRAC_BITS + 1
// divide stages, one multiply stage and the result register. The whole
// pipeline holds while a result waits and rsp_ready is low.
`default_nettype none
module fisheye_remap_address_top
   import fra_pkg::*;
#(
   parameter int MAX_DIM         = 4096,
   parameter int SCALE_FRAC_BITS = 16
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic        [CFG_W-1:0]   width_ff;
   logic        [CFG_W-1:0]   height_ff;
   logic signed [CFG_W-1:0]   cx_ff;
   logic signed [CFG_W-1:0]   cy_ff;
   logic        [FOCAL_W-1:0] focal_ff;
   logic [2*FOCAL_W-1:0]      f2_ff;
   logic [2:0]                reg_index;
   logic                      csr_write;

   logic                      en;
   logic                      v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0]  dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic signed [DIFF_W-1:0]  dx1_in, dy1_in;
   logic signed [2*DIFF_W-1:0] dxsq_full, dysq_full;
   logic [SQ_W-1:0]           dxsq_ff, dysq_ff;
   logic [R2_W-1:0]           r2;
   logic [RAD_W-1:0]          rad_ff, rad_in;
   side_type                  side3_ff;

   logic                      sq_valid;
   logic [ROOT_W-1:0]         sq_root;
   side_type                  sq_side;
   logic                      dv_valid;
   logic [SCALE_FRAC_BITS:0]  dv_scale;
   side_type                  dv_side;
   logic                      vm_ff;
   logic                      in_x, in_y;
   logic [COORD_W-1:0]        crd_x, crd_y;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // configuration port
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1920);
         height_ff <= CFG_W'(1080);
         cx_ff     <= CFG_W'(960);
         cy_ff     <= -CFG_W'(540);
         focal_ff  <= FOCAL_W'(288274);
      end else if (csr_write) begin
         case (reg_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[CFG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[CFG_W-1:0];
            REG_CENTER_X:     cx_ff     <= csr_pwdata[CFG_W-1:0];
            REG_CENTER_Y:     cy_ff     <= csr_pwdata[CFG_W-1:0];
            REG_FOCAL_Q8:     focal_ff  <= csr_pwdata[FOCAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_IMAGE_WIDTH:  csr_prdata = DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = DATA_W'(height_ff);
         REG_CENTER_X:     csr_prdata = DATA_W'(cx_ff);
         REG_CENTER_Y:     csr_prdata = DATA_W'(cy_ff);
         REG_FOCAL_Q8:     csr_prdata = DATA_W'(focal_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // focal squared, refreshed every cycle
   always_ff @(posedge clock) begin
      f2_ff <= focal_ff * focal_ff;
   end

   // whole pipeline advances unless a result is waiting and rsp_ready is low
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // offsets from the center, squares, radicand
   assign dx1_in    = $signed({2'b00, req_data.out_col}) - DIFF_W'(cx_ff);
   assign dy1_in    = $signed({2'b00, req_data.out_row}) - DIFF_W'(cy_ff);
   assign dxsq_full = dx1_ff * dx1_ff;
   assign dysq_full = dy1_ff * dy1_ff;
   assign r2        = {1'b0, dxsq_ff} + {1'b0, dysq_ff};
   assign rad_in    = RAD_W'({f2_ff, 2'b00}) + RAD_W'({r2, 16'b0});

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         dxsq_ff  <= dxsq_full[SQ_W-1:0];
         dysq_ff  <= dysq_full[SQ_W-1:0];
         rad_ff   <= rad_in;
         side3_ff <= '{dx: dx2_ff, dy: dy2_ff, at_center: (r2 == '0)};
      end
   end

   fra_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (rad_ff),
      .in_side   (side3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   fra_div #(.FRAC_W(SCALE_FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .focal     (focal_ff),
      .out_valid (dv_valid),
      .out_scale (dv_scale),
      .out_side  (dv_side)
   );

   fra_map #(.FRAC_W(SCALE_FRAC_BITS), .MAX_DIM(MAX_DIM)) u_map_x (
      .clock     (clock),
      .en        (en),
      .center    (cx_ff),
      .size      (width_ff),
      .diff      (dv_side.dx),
      .scale     (dv_scale),
      .in_bounds (in_x),
      .coord     (crd_x)
   );

   fra_map #(.FRAC_W(SCALE_FRAC_BITS), .MAX_DIM(MAX_DIM)) u_map_y (
      .clock     (clock),
      .en        (en),
      .center    (cy_ff),
      .size      (height_ff),
      .diff      (dv_side.dy),
      .scale     (dv_scale),
      .in_bounds (in_y),
      .coord     (crd_y)
   );

   // result register
   always_comb begin
      rsp_data_in.inside_res = in_x && in_y;
      rsp_data_in.src_col    = (in_x && in_y) ? crd_x : '0;
      rsp_data_in.src_row    = (in_x && in_y) ? crd_y : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vm_ff        <= dv_valid;
         rsp_valid_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### dv/fisheye_remap_address_top_tb.sv
// testbench for the fisheye remap address generator: directed table, random coordinates
`timescale 1ns / 100ps
`default_nettype none
module fisheye_remap_address_top_tb;
   import fra_pkg::*;

   localparam int MAX_DIM    = 4096;
   localparam int FRAC       = 16;
   localparam int LATENCY    = FRAC + 33;
   localparam int WDOG_LIMIT = 20000;
   localparam int N_RANDOM   = 1750;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   // local copy of the registers
   logic [12:0]        img_w;
   logic [12:0]        img_h;
   logic signed [12:0] ctr_x;
   logic signed [12:0] ctr_y;
   logic [23:0]        focal;

   rsp_type src_fifo[$];
   int      error_count;
   int      idle_cycles;
   bit      rx_stall_en;
   bit      hold_off_req;
   bit      done;

   // directed rows: coordinate, known answer where obvious
   typedef struct {
      logic [11:0] col;
      logic [11:0] row;
      bit          has_known;
      rsp_type     known;
   } dir_row_type;

   fisheye_remap_address_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // integer square root, floor
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // one axis of the remap; returns inside and writes the truncated coordinate
   function automatic bit axis_map(longint cen, longint d, longint unsigned scl,
                                   longint unsigned size, output logic [11:0] crd);
      longint          p;
      longint unsigned bnd;
      p = cen * (64'sd1 <<< FRAC) + d * longint'(scl);
      bnd = (size < MAX_DIM) ? size : MAX_DIM;
      if (p < 0 || longint'(p) >= longint'(bnd << FRAC)) begin
         crd = '0;
         return 1'b0;
      end
      crd = 12'(p >>> FRAC);
      return 1'b1;
   endfunction

   function automatic rsp_type source_address(logic [11:0] col, logic [11:0] row);
      longint          dx;
      longint          dy;
      longint unsigned r2;
      longint unsigned rad;
      longint unsigned scl;
      longint unsigned f;
      logic [11:0]     sc;
      logic [11:0]     sr;
      bit              ic;
      bit              ir;
      rsp_type         r;
      f  = focal;
      dx = longint'(col) - longint'(ctr_x);
      dy = longint'(row) - longint'(ctr_y);
      r2 = dx * dx + dy * dy;
      if (r2 == 0) scl = 64'd1 << FRAC;
      else if (f == 0) scl = 0;
      else begin
         rad = 4 * f * f + (r2 << 16);
         scl = ((2 * f) << FRAC) / root_floor(rad);
         if (scl > (64'd1 << FRAC)) scl = 64'd1 << FRAC;
      end
      ic = axis_map(ctr_x, dx, scl, img_w, sc);
      ir = axis_map(ctr_y, dy, scl, img_h, sr);
      r.src_col    = (ic && ir) ? sc : '0;
      r.src_row    = (ic && ir) ? sr : '0;
      r.inside_res = ic && ir;
      return r;
   endfunction

   // register write: setup then access
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = ADDR_W'({idx, 2'b00}); csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:  img_w = val[12:0];
         REG_IMAGE_HEIGHT: img_h = val[12:0];
         REG_CENTER_X:     ctr_x = val[12:0];
         REG_CENTER_Y:     ctr_y = val[12:0];
         REG_FOCAL_Q8:     focal = val[23:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(logic [12:0] w, logic [12:0] h, logic [12:0] cx,
                               logic [12:0] cy, logic [23:0] f);
      csr_write(REG_IMAGE_WIDTH, 32'(w));
      csr_write(REG_IMAGE_HEIGHT, 32'(h));
      csr_write(REG_CENTER_X, 32'(cx));
      csr_write(REG_CENTER_Y, 32'(cy));
      csr_write(REG_FOCAL_Q8, 32'(f));
   endtask

   // send one coordinate; optional random gap first
   task automatic send_coord(logic [11:0] col, logic [11:0] row, bit gaps);
      int n;
      if (gaps && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 7);
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.out_col = col;
      req_data.out_row = row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      src_fifo.push_back(source_address(col, row));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain;
      while (src_fifo.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // result channel: random stall bursts, one long hold-off on request
   initial begin : rx_side
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready = 1'b0;
            repeat (3 * LATENCY) @(negedge clock);
            hold_off_req = 1'b0;
         end
         if (rx_stall_en && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            n = $urandom_range(1, 7);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (src_fifo.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_r = src_fifo.pop_front();
            if (rsp_data.src_col !== exp_r.src_col) begin
               $display("%0t: src_col expected %0d actual %0d", $time,
                        exp_r.src_col, rsp_data.src_col);
               error_count++;
            end
            if (rsp_data.src_row !== exp_r.src_row) begin
               $display("%0t: src_row expected %0d actual %0d", $time,
                        exp_r.src_row, rsp_data.src_row);
               error_count++;
            end
            if (rsp_data.inside_res !== exp_r.inside_res) begin
               $display("%0t: inside_res expected %0b actual %0b", $time,
                        exp_r.inside_res, rsp_data.inside_res);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         idle_cycles <= 0;
      else if (!done)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // main sequence
   initial begin : stim
      dir_row_type dir_tab[$];
      dir_row_type dr;
      rsp_type     exp_r;
      logic [11:0] c;
      logic [11:0] r;
      int          k;
      int          phase;
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      error_count = 0; idle_cycles = 0; rx_stall_en = 1'b0;
      hold_off_req = 1'b0; done = 1'b0;
      img_w = 13'd1920; img_h = 13'd1080; ctr_x = 13'sd960; ctr_y = -13'sd540;
      focal = 24'd288274;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows under reset settings; the rows with a known answer expect an outside result
      dir_tab.push_back('{12'd0, 12'd0, 0, '0});
      dir_tab.push_back('{12'd4095, 12'd4095, 1, '0});
      dir_tab.push_back('{12'd960, 12'd0, 0, '0});
      dir_tab.push_back('{12'd4095, 12'd0, 0, '0});
      dir_tab.push_back('{12'd0, 12'd4095, 1, '0});
      dir_tab.push_back('{12'd1919, 12'd1079, 0, '0});
      dir_tab.push_back('{12'hAAA, 12'h555, 0, '0});
      dir_tab.push_back('{12'h555, 12'hAAA, 0, '0});
      foreach (dir_tab[i]) begin
         dr = dir_tab[i];
         send_coord(dr.col, dr.row, 1'b0);
         if (dr.has_known) begin
            exp_r = src_fifo[$];
            if (exp_r !== dr.known) begin
               $display("%0t: table row %0d expected %h actual %h", $time, i,
                        dr.known, exp_r);
               error_count++;
            end
         end
      end
      drain();

      // center pixel: scale exactly one, maps to itself
      set_geometry(13'd4096, 13'd4096, 13'sd100, 13'sd200, 24'd1000);
      send_coord(12'd100, 12'd200, 1'b0);
      if (src_fifo[$] !== rsp_type'({12'd100, 12'd200, 1'b1})) begin
         $display("%0t: center expected %h actual %h", $time,
                  rsp_type'({12'd100, 12'd200, 1'b1}), src_fifo[$]);
         error_count++;
      end
      drain();
      // focal zero: off-center collapses to the center
      csr_write(REG_FOCAL_Q8, 32'd0);
      send_coord(12'd0, 12'd0, 1'b0);
      send_coord(12'd4095, 12'd4095, 1'b0);
      send_coord(12'd100, 12'd200, 1'b0);
      drain();
      // size zero and oversize, extreme centers and focal
      set_geometry(13'd0, 13'd0, 13'h1000, 13'h0FFF, 24'hFFFFFF);
      send_coord(12'd0, 12'd0, 1'b0);
      send_coord(12'd4095, 12'd4095, 1'b0);
      drain();
      set_geometry(13'h1FFF, 13'h1FFF, 13'h0FFF, 13'h1000, 24'd1);
      send_coord(12'd0, 12'd4095, 1'b0);
      send_coord(12'd4095, 12'd0, 1'b0);
      drain();

      // random phases with new geometry, then pressure, then no idling
      rx_stall_en = 1'b1;
      for (phase = 0; phase < 7; phase++) begin
         if (phase == 6) rx_stall_en = 1'b0;
         case (phase)
            0: set_geometry(13'd1920, 13'd1080, 13'sd960, -13'sd540, 24'd288274);
            1: set_geometry(13'd4096, 13'd4096, 13'sd2048, 13'sd2048, 24'd65536);
            2: set_geometry(13'd1, 13'd1, 13'sd0, 13'sd0, 24'd256);
            default: set_geometry(13'($urandom_range(1, 8191)),
                                  13'($urandom_range(1, 8191)),
                                  13'($urandom), 13'($urandom),
                                  24'($urandom_range(0, 1) ? $urandom_range(1, 4000000)
                                                           : $urandom));
         endcase
         if (phase == 4) hold_off_req = 1'b1;
         for (k = 0; k < N_RANDOM / 7; k++) begin
            case ($urandom_range(0, 3))
               0: begin c = 12'($urandom); r = 12'($urandom); end
               1: begin
                  c = 12'(int'(ctr_x) + $urandom_range(0, 64) - 32);
                  r = 12'(int'(ctr_y) + $urandom_range(0, 64) - 32);
               end
               default: begin
                  c = 12'($urandom_range(0, (img_w > 4096) ? 4095 : img_w));
                  r = 12'($urandom_range(0, (img_h > 4096) ? 4095 : img_h));
               end
            endcase
            send_coord(c, r, phase != 6);
         end
         drain();
      end

      done = 1'b1;
      if (error_count == 0 && src_fifo.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire

### fisheye_remap_address_top.f
design/fra_pkg.sv
design/fra_sqrt.sv
design/fra_div.sv
design/fra_map.sv
design/fisheye_remap_address_top.sv
dv/fisheye_remap_address_top_tb.sv
